### sv/pelog_pkg.sv
`default_nettype none

package pelog_pkg;

    localparam int CAPACITY = 256;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam int INTERVAL_MIN = 10;
    localparam int INTERVAL_MAX = 86400;
    localparam int INTERVAL_RESET = 300;
    localparam int MS_PER_S = 1000;
    localparam int IV_W = 17;
    localparam int IMS_W = $clog2(INTERVAL_MAX * MS_PER_S + 1);

    localparam int LEVEL_MAX = 100;
    localparam int MV_MIN = 11;
    localparam int MV_MAX = 5000;

    localparam logic [7:0] SCREEN_UNSEEN = 8'hFF;
    localparam logic [7:0] LEVEL_INVALID = 8'hFF;

    localparam logic [1:0] KIND_BOOT = 2'd0;
    localparam logic [1:0] KIND_SCREEN = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [31:0]        now_ms;
        logic [7:0]         screen_number;
        logic signed [8:0]  battery_percent;
        logic [15:0]        battery_millivolts;
        logic signed [32:0] utc_seconds;
        logic [7:0]         read_position;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  percent;
        logic [12:0] millivolts;
        logic [7:0]  screen;
        logic [31:0] time_s;
    } t_record;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  record_percent;
        logic [12:0] record_millivolts;
        logic [7:0]  record_screen;
        logic [31:0] record_time;
        logic        record_valid;
        logic [8:0]  records_held;
        logic [1:0]  records_added;
    } t_result;

    typedef struct packed {
        logic             logging_en;
        logic [IMS_W-1:0] interval_ms;
    } t_cfg;

endpackage

`default_nettype wire

### sv/periodic_event_ring_logger.sv
// Channel  | Direction | Handshake                     | Payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser action, tdata input fields
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tuser record kind, tdata result
// APB      | in        | psel, penable, pready         | 0x0 logging_enabled, 0x4 interval
//
// A result is loaded into the output register in DONE after its item passes through EXEC, and
// also through WR2 for a tick that appends two records, since each record takes one ring write.
// The input is ready only in IDLE, so the next item waits until the last one has left DONE.
// Reads use the memory's registered read port: the record is read in EXEC and used in DONE.
// Reset is synchronous and active low; the ring starts empty with no clearing pass.
// The next item is accepted while a result waits, then holds until the output register frees.
`default_nettype none

module periodic_event_ring_logger (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: now_ms, screen_number, battery_percent, battery_millivolts,
    // utc_seconds, read_position
    input  logic [111:0]  s_axis_tdata,
    // tuser: action
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: record_percent, record_millivolts, record_screen, record_time,
    // record_valid, records_held, records_added
    output logic [79:0]   m_axis_tdata,
    // tuser: record_kind
    output logic [1:0]    m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import pelog_pkg::*;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    logic             r_enable;
    logic [IV_W-1:0]  r_interval;
    logic [IMS_W-1:0] r_interval_ms;
    logic [IV_W-1:0]  iv_clamped;
    logic             apb_wr;
    logic             start;
    t_cfg             cfg;
    t_item            item;
    t_result          res;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (pwdata[IV_W-1:0] < IV_W'(INTERVAL_MIN)) begin
            iv_clamped = IV_W'(INTERVAL_MIN);
        end else if (pwdata[IV_W-1:0] > IV_W'(INTERVAL_MAX)) begin
            iv_clamped = IV_W'(INTERVAL_MAX);
        end else begin
            iv_clamped = pwdata[IV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_interval <= IV_W'(INTERVAL_RESET);
            r_interval_ms <= IMS_W'(INTERVAL_RESET * MS_PER_S);
        end else begin
            if (start) begin
                r_enable <= 1'b1;
            end else if (apb_wr && paddr[2] == REG_ENABLE) begin
                r_enable <= pwdata[0];
            end
            if (apb_wr && paddr[2] == REG_INTERVAL) begin
                r_interval <= iv_clamped;
                r_interval_ms <= IMS_W'(iv_clamped) * IMS_W'(MS_PER_S);
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENABLE:   prdata = {31'b0, r_enable};
            REG_INTERVAL: prdata = 32'(r_interval);
        endcase
    end

    assign cfg.logging_en = r_enable;
    assign cfg.interval_ms = r_interval_ms;

    assign item.action = t_action'(s_axis_tuser);
    assign item.now_ms = s_axis_tdata[31:0];
    assign item.screen_number = s_axis_tdata[39:32];
    assign item.battery_percent = s_axis_tdata[48:40];
    assign item.battery_millivolts = s_axis_tdata[64:49];
    assign item.utc_seconds = s_axis_tdata[97:65];
    assign item.read_position = s_axis_tdata[105:98];

    pelog_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .o_start     (start),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tuser = res.record_kind;
    assign m_axis_tdata = {7'b0, res.records_added, res.records_held, res.record_valid,
                           res.record_time, res.record_screen, res.record_millivolts,
                           res.record_percent};

endmodule

`default_nettype wire

### sv/pelog_fmt.sv
`default_nettype none

module pelog_fmt (
    input  pelog_pkg::t_item   i_item,
    input  logic [1:0]         i_kind,
    output pelog_pkg::t_record o_rec
);
    import pelog_pkg::*;

    always_comb begin
        o_rec.kind = i_kind;
        o_rec.screen = i_item.screen_number;
        if (i_item.battery_percent[8] || i_item.battery_percent[7:0] > 8'(LEVEL_MAX)) begin
            o_rec.percent = LEVEL_INVALID;
        end else begin
            o_rec.percent = i_item.battery_percent[7:0];
        end
        if (i_item.battery_millivolts < 16'(MV_MIN) ||
            i_item.battery_millivolts > 16'(MV_MAX)) begin
            o_rec.millivolts = '0;
        end else begin
            o_rec.millivolts = i_item.battery_millivolts[12:0];
        end
        if (i_item.utc_seconds[32]) begin
            o_rec.time_s = '0;
        end else begin
            o_rec.time_s = i_item.utc_seconds[31:0];
        end
    end

endmodule

`default_nettype wire

### sv/pelog_ctrl.sv
`default_nettype none

module pelog_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pelog_pkg::t_cfg    i_cfg,
    output logic               o_start,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pelog_pkg::t_item   i_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pelog_pkg::t_result o_out
);
    import pelog_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WR2  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_item           r_item, n_item;
    logic [AW-1:0]   r_wp, n_wp;
    logic [CW-1:0]   r_held, n_held;
    logic [31:0]     r_last, n_last;
    logic [7:0]      r_prev, n_prev;
    logic [1:0]      r_added, n_added;
    logic            r_hit, n_hit;
    logic            r_ovalid, n_ovalid;
    t_result         r_out, n_out;

    t_record         r_mem [CAPACITY];
    t_record         r_rd_rec;
    t_record         wr_rec;
    logic            wr_en;
    logic [1:0]      wr_kind;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic [31:0]     elapsed;
    logic            scr_chg;
    logic            smp;
    logic            out_free;

    pelog_fmt u_fmt (
        .i_item (r_item),
        .i_kind (wr_kind),
        .o_rec  (wr_rec)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= wr_rec;
        end
        if (rd_en) begin
            r_rd_rec <= r_mem[rd_addr];
        end
    end

    assign elapsed = r_item.now_ms - r_last;
    assign scr_chg = i_cfg.logging_en && r_prev != SCREEN_UNSEEN &&
                     r_item.screen_number != r_prev;
    assign smp = i_cfg.logging_en && elapsed >= 32'(i_cfg.interval_ms);
    assign rd_addr = r_wp - r_held[AW-1:0] + AW'(r_item.read_position);
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_wp = r_wp;
        n_held = r_held;
        n_last = r_last;
        n_prev = r_prev;
        n_added = r_added;
        n_hit = r_hit;
        n_ovalid = r_ovalid;
        n_out = r_out;
        wr_en = 1'b0;
        wr_kind = KIND_BOOT;
        rd_en = 1'b0;
        o_start = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_item;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                n_added = 2'd0;
                n_hit = 1'b0;
                unique case (r_item.action)
                    ACT_TICK: begin
                        if (i_cfg.logging_en) begin
                            n_prev = r_item.screen_number;
                            wr_en = scr_chg || smp;
                            wr_kind = scr_chg ? KIND_SCREEN : KIND_SAMPLE;
                            if (smp) begin
                                n_last = r_item.now_ms;
                            end
                            n_added = {1'b0, scr_chg} + {1'b0, smp};
                            if (scr_chg && smp) begin
                                n_state = ST_WR2;
                            end
                        end
                    end
                    ACT_START: begin
                        o_start = 1'b1;
                        n_last = r_item.now_ms;
                        n_prev = r_item.screen_number;
                        wr_en = 1'b1;
                        wr_kind = KIND_BOOT;
                        n_added = 2'd1;
                    end
                    ACT_CLEAR: begin
                        n_wp = '0;
                        n_held = '0;
                    end
                    ACT_READ: begin
                        rd_en = 1'b1;
                        n_hit = CW'(r_item.read_position) < r_held;
                    end
                endcase
            end
            ST_WR2: begin
                wr_en = 1'b1;
                wr_kind = KIND_SAMPLE;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    if (r_hit) begin
                        n_out.record_kind = r_rd_rec.kind;
                        n_out.record_percent = r_rd_rec.percent;
                        n_out.record_millivolts = r_rd_rec.millivolts;
                        n_out.record_screen = r_rd_rec.screen;
                        n_out.record_time = r_rd_rec.time_s;
                        n_out.record_valid = 1'b1;
                    end
                    n_out.records_held = 9'(r_held);
                    n_out.records_added = r_added;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (wr_en) begin
            n_wp = r_wp + AW'(1);
            if (r_held < CW'(CAPACITY)) begin
                n_held = r_held + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp <= '0;
            r_held <= '0;
            r_last <= '0;
            r_prev <= SCREEN_UNSEEN;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp <= n_wp;
            r_held <= n_held;
            r_last <= n_last;
            r_prev <= n_prev;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_added <= n_added;
        r_hit <= n_hit;
        r_out <= n_out;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !wr_en)
        else $error("memory written while idle");

    a_second_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR2) |-> $past(wr_en))
        else $error("second record without a first");

    a_hit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.record_valid) |-> (r_out.records_held != '0))
        else $error("valid read from an empty ring");
`endif

endmodule

`default_nettype wire

### test/pelog_tb_pkg.sv
`timescale 1ns / 100ps

package pelog_tb_pkg;

    localparam logic [2:0] REG_LOGGING_ENABLE  = 3'h0;
    localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'h4;

    // Layout of the input item on s_axis_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]         pad;
        logic [7:0]         read_position;
        logic signed [32:0] utc_seconds;
        logic [15:0]        millivolts;
        logic signed [8:0]  percent;
        logic [7:0]         screen;
        logic [31:0]        now_ms;
    } t_in_beat;

    // Layout of the result item on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]  pad;
        logic [1:0]  records_added;
        logic [8:0]  records_held;
        logic        record_valid;
        logic [31:0] record_time;
        logic [7:0]  record_screen;
        logic [12:0] record_millivolts;
        logic [7:0]  record_percent;
    } t_out_beat;

endpackage

### test/pelog_checker.sv
`timescale 1ns / 100ps

module pelog_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [111:0] i_in_data,
    input  logic [1:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [79:0]  i_out_data,
    input  logic [1:0]   i_out_user,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked,
    output int           o_hits
);
    import pelog_pkg::*;
    import pelog_tb_pkg::*;

    localparam int MAX_REPORTS = 50;

    t_record          ring_store [CAPACITY];
    logic [AW-1:0]    write_ptr;
    logic [CW-1:0]    held;
    logic [31:0]      last_sample_ms;
    logic [7:0]       last_screen;
    logic             log_en;
    logic [IV_W-1:0]  interval_s;
    t_result          awaited_results [$];

    function automatic t_record pack_record(logic [1:0] kind, t_in_beat b);
        t_record r;
        r.kind = kind;
        r.percent = (b.percent[8] || b.percent[7:0] > LEVEL_MAX) ? LEVEL_INVALID
                                                                 : b.percent[7:0];
        r.millivolts = (b.millivolts < MV_MIN || b.millivolts > MV_MAX) ? 13'd0
                                                                       : b.millivolts[12:0];
        r.screen = b.screen;
        r.time_s = b.utc_seconds[32] ? 32'd0 : b.utc_seconds[31:0];
        return r;
    endfunction

    function automatic void log_record(t_record r);
        ring_store[write_ptr] = r;
        write_ptr = write_ptr + 1'b1;
        if (held < CAPACITY) begin
            held = held + 1'b1;
        end
    endfunction

    function automatic t_result logger_response(t_action act, t_in_beat b);
        t_result       r;
        t_record       rec;
        logic [31:0]   elapsed;
        logic [31:0]   interval_ms;
        logic [AW-1:0] slot;
        r = '0;
        interval_ms = interval_s * MS_PER_S;
        elapsed = b.now_ms - last_sample_ms;
        case (act)
            ACT_TICK: begin
                if (log_en) begin
                    if (last_screen == SCREEN_UNSEEN) begin
                        last_screen = b.screen;
                    end
                    if (b.screen != last_screen) begin
                        last_screen = b.screen;
                        log_record(pack_record(KIND_SCREEN, b));
                        r.records_added = r.records_added + 2'd1;
                    end
                    if (elapsed >= interval_ms) begin
                        last_sample_ms = b.now_ms;
                        log_record(pack_record(KIND_SAMPLE, b));
                        r.records_added = r.records_added + 2'd1;
                    end
                end
            end
            ACT_START: begin
                log_en = 1'b1;
                last_sample_ms = b.now_ms;
                last_screen = b.screen;
                log_record(pack_record(KIND_BOOT, b));
                r.records_added = 2'd1;
            end
            ACT_CLEAR: begin
                write_ptr = '0;
                held = '0;
            end
            ACT_READ: begin
                if (b.read_position < held) begin
                    slot = write_ptr - held[AW-1:0] + b.read_position;
                    rec = ring_store[slot];
                    r.record_kind = rec.kind;
                    r.record_percent = rec.percent;
                    r.record_millivolts = rec.millivolts;
                    r.record_screen = rec.screen;
                    r.record_time = rec.time_s;
                    r.record_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.records_held = held;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (o_fail_count < MAX_REPORTS) begin
            $display("ERROR %0t: result %0d: %s", $time, o_checked, msg);
        end
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat       beat;
        t_result         want;
        logic [IV_W-1:0] new_interval;
        if (!i_rst_n) begin
            write_ptr = '0;
            held = '0;
            last_sample_ms = '0;
            last_screen = SCREEN_UNSEEN;
            log_en = 1'b0;
            interval_s = IV_W'(INTERVAL_RESET);
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_LOGGING_ENABLE: begin
                        log_en = i_pwdata[0];
                    end
                    REG_SAMPLE_INTERVAL: begin
                        new_interval = i_pwdata[IV_W-1:0];
                        if (new_interval < INTERVAL_MIN) begin
                            new_interval = IV_W'(INTERVAL_MIN);
                        end else if (new_interval > INTERVAL_MAX) begin
                            new_interval = IV_W'(INTERVAL_MAX);
                        end
                        interval_s = new_interval;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(
                    logger_response(t_action'(i_in_user), t_in_beat'(i_in_data)));
            end
            if (i_out_valid && i_out_ready) begin
                beat = i_out_data;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result arrived with no item waiting for one");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("record_kind", i_out_user, want.record_kind);
                    check_field("record_percent", beat.record_percent, want.record_percent);
                    check_field("record_millivolts", beat.record_millivolts,
                                want.record_millivolts);
                    check_field("record_screen", beat.record_screen, want.record_screen);
                    check_field("record_time", beat.record_time, want.record_time);
                    check_field("record_valid", beat.record_valid, want.record_valid);
                    check_field("records_held", beat.records_held, want.records_held);
                    check_field("records_added", beat.records_added, want.records_added);
                    check_field("tdata padding", beat.pad, 7'd0);
                    o_checked++;
                    if (want.record_valid) begin
                        o_hits++;
                    end
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pelog_pkg::*;
    import pelog_tb_pkg::*;

    localparam int CLK_PERIOD_NS  = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_TAIL     = 8;
    localparam int PHASE_ITEMS    = 145;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int           fail_count;
    int           pending;
    int           checked;
    int           hits;

    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_request = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           action_count [4] = '{0, 0, 0, 0};
    logic [31:0]  cur_ms;
    logic [7:0]   cur_screen;
    int           cur_interval_ms;

    periodic_event_ring_logger dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pelog_checker record_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(t_action act, t_in_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= beat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        action_count[act]++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic t_in_beat beat_of(logic [31:0] now, logic [7:0] screen, int level,
                                         logic [15:0] mv, logic [32:0] utc,
                                         logic [7:0] pos);
        t_in_beat b;
        b = '0;
        b.now_ms = now;
        b.screen = screen;
        b.percent = level[8:0];
        b.millivolts = mv;
        b.utc_seconds = utc;
        b.read_position = pos;
        return b;
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        int       pick;
        int       level;
        b = '0;
        pick = $urandom_range(9);
        if (pick < 5) begin
            cur_ms = cur_ms + $urandom_range(1999);
        end else if (pick < 8) begin
            cur_ms = cur_ms + $urandom_range(2 * cur_interval_ms);
        end else if (pick == 8) begin
            cur_ms = $urandom;
        end else begin
            cur_ms = cur_ms + cur_interval_ms;
        end
        b.now_ms = cur_ms;
        if ($urandom_range(1) == 0) begin
            cur_screen = 8'($urandom_range(255));
        end
        b.screen = cur_screen;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3, 4: level = $urandom_range(100);
            5: level = $urandom_range(255, 101);
            6, 7: level = -int'($urandom_range(128, 1));
            default: begin
                case ($urandom_range(3))
                    0: level = 100;
                    1: level = 101;
                    2: level = -1;
                    default: level = -128;
                endcase
            end
        endcase
        b.percent = level[8:0];
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3, 4, 5: b.millivolts = 16'($urandom_range(MV_MAX, MV_MIN));
            6: b.millivolts = 16'($urandom_range(MV_MIN - 1));
            7: b.millivolts = 16'($urandom_range(65535, MV_MAX + 1));
            8: begin
                case ($urandom_range(3))
                    0: b.millivolts = 16'd10;
                    1: b.millivolts = 16'd11;
                    2: b.millivolts = 16'd5000;
                    default: b.millivolts = 16'd5001;
                endcase
            end
            default: b.millivolts = 16'($urandom);
        endcase
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3, 4, 5: b.utc_seconds = {1'b0, 32'($urandom)};
            6: b.utc_seconds = '0;
            7: b.utc_seconds = -33'($urandom_range(32'h8000_0000, 1));
            8: b.utc_seconds = 33'h0_FFFF_FFFF;
            default: b.utc_seconds = 33'h1_8000_0000;
        endcase
        b.read_position = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(31));
        return b;
    endfunction

    task automatic run_phase(int idle_pct, int stall_pct, logic [31:0] enable_word,
                             logic [31:0] interval_word, int interval_sec, bit allow_clear,
                             bit hold_midway, bit pause_midway);
        int      pick;
        t_action act;
        write_reg(REG_LOGGING_ENABLE, enable_word);
        write_reg(REG_SAMPLE_INTERVAL, interval_word);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        cur_interval_ms = interval_sec * MS_PER_S;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) begin
                if (hold_midway) begin
                    hold_request = HOLD_CYCLES;
                end
                if (pause_midway) begin
                    wait_drained();
                end
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                act = ACT_TICK;
            end else if (pick < 68) begin
                act = ACT_START;
            end else if (pick < 70) begin
                act = allow_clear ? ACT_CLEAR : ACT_TICK;
            end else begin
                act = ACT_READ;
            end
            send_item(act, rand_beat());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_TICK;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_LOGGING_ENABLE;
        pwdata = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: logging off, so the tick must be ignored.
        send_item(ACT_TICK, beat_of(32'd500, 8'd3, 50, 16'd3300, 33'd1000, 8'd0));
        send_item(ACT_READ, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'd0));
        send_item(ACT_READ, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'd255));
        wait_drained();
        write_reg(REG_LOGGING_ENABLE, 32'h1);

        // The first tick only learns the screen; the reset interval is 300 s.
        send_item(ACT_TICK, beat_of(32'd1000, 8'd5, 50, 16'd3300, 33'd1000, 8'd0));
        send_item(ACT_TICK, beat_of(32'd299999, 8'd5, 50, 16'd3300, 33'd1000, 8'd0));
        send_item(ACT_TICK, beat_of(32'd300000, 8'd6, 0, 16'd11, 33'd1, 8'd0));
        send_item(ACT_TICK, beat_of(32'd300001, 8'd255, 101, 16'd10, 33'd0, 8'd0));
        send_item(ACT_TICK, beat_of(32'd300002, 8'd9, 255, 16'd5001, 33'h1_FFFF_FFFF,
                                    8'd0));
        send_item(ACT_START, beat_of(32'hFFFF_FF00, 8'd200, -128, 16'hFFFF, 33'h1_8000_0000,
                                     8'd0));
        // The sample timer must wrap across 2^32 milliseconds.
        send_item(ACT_TICK, beat_of(32'hFFFF_FF00 + 32'd300000, 8'd200, 100, 16'd5000,
                                    33'h0_FFFF_FFFF, 8'd0));
        for (int p = 0; p < 5; p++) begin
            send_item(ACT_READ, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'(p)));
        end
        send_item(ACT_READ, beat_of(32'hFFFF_FFFF, 8'hFF, -1, 16'hFFFF, 33'h1_FFFF_FFFF,
                                    8'd255));
        send_item(ACT_CLEAR, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'd0));
        send_item(ACT_READ, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'd0));
        send_item(ACT_TICK, beat_of(32'h0004_92E1, 8'd7, 42, 16'd4200, 33'd12345, 8'd0));
        send_item(ACT_READ, beat_of(32'd0, 8'd0, 0, 16'd0, 33'd0, 8'd0));
        wait_drained();

        cur_ms = 32'h0004_9300;
        cur_screen = 8'd7;
        run_phase(0, 0, 32'hFFFF_FFFF, 32'h0000_0005, INTERVAL_MIN, 1'b0, 1'b1, 1'b0);
        run_phase(85, 0, 32'h0000_0001, 32'hFFFF_FFFF, INTERVAL_MAX, 1'b0, 1'b0, 1'b1);
        run_phase(0, 85, 32'h2468_ACE1, 32'hFFFE_012C, INTERVAL_RESET, 1'b0, 1'b1, 1'b0);
        run_phase(37, 37, 32'hFFFF_FFFE, 32'h0001_5180, INTERVAL_MAX, 1'b1, 1'b0, 1'b1);

        repeat (DRAIN_TAIL) @(negedge i_clk);
        $display("Summary: %0d ticks, %0d starts, %0d clears, %0d reads; %0d results checked,",
                 action_count[ACT_TICK], action_count[ACT_START], action_count[ACT_CLEAR],
                 action_count[ACT_READ], checked);
        $display("Summary: %0d reads hit held records; intervals 10/300/86400 s, %s",
                 hits, "idle and stall mixes, a long output hold-off and full drains.");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
